// ===== rtl/rcde_pkg.sv =====
// ----------------------------------------------------------------------------
// rcde_pkg
// Shared types, constants and the control store of the canvas draw engine.
// ----------------------------------------------------------------------------
package rcde_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0]    BLANK_CHAR  = 8'h20;
  localparam logic [SIZE_W-1:0]    SIZE_RESET  = 7'd64;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 1'b1;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_SET   = 3'd1,
    ACT_RECT  = 3'd2,
    ACT_RING  = 3'd3,
    ACT_READ  = 3'd4
  } action_t;

  // sequencer step addresses
  typedef enum logic [2:0] {
    ST_WIPE  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_SET   = 3'd2,
    ST_READ  = 3'd3,
    ST_RING  = 3'd4,
    ST_SCAN  = 3'd5,
    ST_DRAIN = 3'd6,
    ST_EMIT  = 3'd7
  } step_t;

  // jump conditions: jump when true (to target, or for dispatch to the entry step), else hold the step
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_DISPATCH = 3'd1,
    C_SCAN     = 3'd2,
    C_EMIT     = 3'd3,
    C_WIPE     = 3'd4
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  wipe;
    logic  cell_wr;
    logic  cell_rd;
    logic  sq_setup;
    logic  scan;
    logic  emit;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{accept: 1'b0, wipe: 1'b0, cell_wr: 1'b0, cell_rd: 1'b0, sq_setup: 1'b0,
          scan: 1'b0, emit: 1'b0, cond: C_ALWAYS, target: ST_IDLE};
    unique case (s)
      ST_WIPE: begin
        w.wipe = 1'b1;  w.cond = C_WIPE;  w.target = ST_IDLE;
      end
      ST_IDLE: begin
        w.accept = 1'b1;  w.cond = C_DISPATCH;  w.target = ST_IDLE;
      end
      ST_SET: begin
        w.cell_wr = 1'b1;  w.target = ST_EMIT;
      end
      ST_READ: begin
        w.cell_rd = 1'b1;  w.target = ST_EMIT;
      end
      ST_RING: begin
        w.sq_setup = 1'b1;  w.target = ST_SCAN;
      end
      ST_SCAN: begin
        w.scan = 1'b1;  w.cond = C_SCAN;  w.target = ST_DRAIN;
      end
      ST_DRAIN: begin
        w.target = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit = 1'b1;  w.cond = C_EMIT;  w.target = ST_IDLE;
      end
      default: begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry step of each command
  function automatic step_t entry_step(logic [2:0] act);
    step_t s;
    unique case (action_t'(act))
      ACT_CLEAR: s = ST_SCAN;
      ACT_SET:   s = ST_SET;
      ACT_RECT:  s = ST_SCAN;
      ACT_RING:  s = ST_RING;
      ACT_READ:  s = ST_READ;
      default:   s = ST_EMIT;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/rcde_if.sv =====
// ----------------------------------------------------------------------------
// rcde_if
// Command and result channels of the canvas draw engine (valid/ready).
// ----------------------------------------------------------------------------
interface rcde_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          action;
  logic signed [rcde_pkg::COORD_W-1:0] row_a;
  logic signed [rcde_pkg::COORD_W-1:0] col_a;
  logic signed [rcde_pkg::COORD_W-1:0] row_b;
  logic signed [rcde_pkg::COORD_W-1:0] col_b;
  logic [7:0]                          radius;
  logic [rcde_pkg::CHAR_W-1:0]         fill_char;

  modport source (output valid, action, row_a, col_a, row_b, col_b, radius, fill_char,
                  input ready);
  modport sink   (input valid, action, row_a, col_a, row_b, col_b, radius, fill_char,
                  output ready);
endinterface

interface rcde_res_if;
  logic                        valid;
  logic                        ready;
  logic [rcde_pkg::CHAR_W-1:0] read_char;
  logic                        point_inside;

  modport source (output valid, read_char, point_inside, input ready);
  modport sink   (input valid, read_char, point_inside, output ready);
endinterface

// ===== rtl/raster_canvas_draw_engine.sv =====
// ----------------------------------------------------------------------------
// raster_canvas_draw_engine
// Character canvas with clear, set, rectangle outline, circle ring and read.
// ----------------------------------------------------------------------------
// Usage notes
// - in_cmd: one command per transaction (valid/ready). Taken only while the
//   sequencer sits in its idle step; every command returns one transaction on
//   out_res, in command order.
// - cfg_*: canvas width (index 0) and height (index 1), written while idle.
// - Reset: size registers go to 64 and a wipe pass writes a space into every
//   cell, one cell a cycle, over all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells
//   (4096 at the defaults). in_cmd.ready stays low until it ends.
// - Steps per command: set and read pass their own step, then emit; an
//   unused action goes straight to emit; clear and rectangle scan, drain
//   and emit; circle adds a ring setup step before the scan. The rows and
//   cols scanned are the in-use canvas size (an empty canvas still passes
//   through the scan step). The scan of clear, rectangle and circle visits one
//   cell a cycle through the single write port of the frame store; that scan
//   sets the rate.
// - The result sits in an output register; a stalled receiver holds the
//   sequencer in its emit step, and the next command waits until the
//   result register can be loaded.
// ----------------------------------------------------------------------------
module raster_canvas_draw_engine #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rcde_cmd_if.sink                         in_cmd,
  rcde_res_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [rcde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcde_pkg::SIZE_W-1:0]      cfg_wdata
);
  import rcde_pkg::*;

  // index widths of the frame store
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [8:0]  ROWS_LIM = 9'(MAX_ROWS);
  localparam logic [8:0]  COLS_LIM = 9'(MAX_COLS);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] cfg_w_r, cfg_h_r;
  logic [8:0]        used_cols, used_rows;
  logic              area_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= SIZE_RESET;
      cfg_h_r <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH)  cfg_w_r <= cfg_wdata;
      if (cfg_index == CFG_HEIGHT) cfg_h_r <= cfg_wdata;
    end
  end

  // sizes above the store are clipped to it
  assign used_cols = (9'(cfg_w_r) > COLS_LIM) ? COLS_LIM : 9'(cfg_w_r);
  assign used_rows = (9'(cfg_h_r) > ROWS_LIM) ? ROWS_LIM : 9'(cfg_h_r);
  assign area_on   = (used_cols != 9'd0) && (used_rows != 9'd0);

  // --------------------------------------------------------------------------
  // Sequencer: step counter and control store
  // --------------------------------------------------------------------------
  step_t  step_r, step_nxt;
  ucode_t uc;
  logic   accept, out_free, scan_last, wipe_last;

  assign uc       = ucode_rom(step_r);
  assign accept   = in_cmd.valid && uc.accept;
  assign out_free = !out_res.valid || out_res.ready;

  always_comb begin
    step_nxt = step_r;
    case (uc.cond)
      C_ALWAYS:   step_nxt = uc.target;
      C_DISPATCH: if (accept)    step_nxt = entry_step(in_cmd.action);
      C_SCAN:     if (scan_last) step_nxt = uc.target;
      C_EMIT:     if (out_free)  step_nxt = uc.target;
      C_WIPE:     if (wipe_last) step_nxt = uc.target;
      default:    step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= ST_WIPE;
    else        step_r <= step_nxt;
  end

  assign in_cmd.ready = uc.accept;

  // --------------------------------------------------------------------------
  // Command registers, loaded on acceptance
  // --------------------------------------------------------------------------
  logic [2:0]                act_r;
  logic signed [COORD_W-1:0] ra_r, ca_r;
  logic signed [COORD_W-1:0] lo_r_r, hi_r_r, lo_c_r, hi_c_r;
  logic [7:0]                rad_r;
  logic [CHAR_W-1:0]         fill_r;
  logic                      inside_r;
  logic                      in_area, act_pt;

  assign in_area = !in_cmd.row_a[COORD_W-1] && !in_cmd.col_a[COORD_W-1] &&
                   (9'($unsigned(in_cmd.row_a)) < used_rows) &&
                   (9'($unsigned(in_cmd.col_a)) < used_cols);
  assign act_pt  = (in_cmd.action == ACT_SET)  || (in_cmd.action == ACT_RECT) ||
                   (in_cmd.action == ACT_RING) || (in_cmd.action == ACT_READ);

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_cmd.action;
      ra_r     <= in_cmd.row_a;
      ca_r     <= in_cmd.col_a;
      lo_r_r   <= (in_cmd.row_a < in_cmd.row_b) ? in_cmd.row_a : in_cmd.row_b;
      hi_r_r   <= (in_cmd.row_a < in_cmd.row_b) ? in_cmd.row_b : in_cmd.row_a;
      lo_c_r   <= (in_cmd.col_a < in_cmd.col_b) ? in_cmd.col_a : in_cmd.col_b;
      hi_c_r   <= (in_cmd.col_a < in_cmd.col_b) ? in_cmd.col_b : in_cmd.col_a;
      rad_r    <= in_cmd.radius;
      fill_r   <= in_cmd.fill_char;
      inside_r <= in_area && act_pt;
    end
  end

  // ring bounds: r*r and (r+1)*(r+1)
  logic [16:0] inner_r, outer_r;
  logic [8:0]  rad_p1;

  assign rad_p1 = 9'(rad_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (uc.sq_setup) begin
      inner_r <= 17'(rad_r) * 17'(rad_r);
      outer_r <= 17'(rad_p1) * 17'(rad_p1);
    end
  end

  // --------------------------------------------------------------------------
  // Scan counters over the in-use area, and wipe counter
  // --------------------------------------------------------------------------
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic          col_last, row_last;
  logic [AW-1:0] wipe_r;

  assign col_last  = (9'(col_r) + 9'd1) >= used_cols;
  assign row_last  = (9'(row_r) + 9'd1) >= used_rows;
  assign scan_last = (col_last && row_last) || !area_on;
  assign wipe_last = &wipe_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= '0;
      col_r <= '0;
    end else if (uc.scan) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       wipe_r <= '0;
    else if (uc.wipe) wipe_r <= wipe_r + AW'(1);
  end

  // --------------------------------------------------------------------------
  // Scan pipeline: stage 1 squares and box test, stage 2 ring test and write
  // --------------------------------------------------------------------------
  logic signed [9:0]  cur_r, cur_c, dr, dc;
  logic signed [9:0]  lo_r10, hi_r10, lo_c10, hi_c10;
  logic signed [19:0] dr_sq, dc_sq;
  logic               box_hit;

  assign cur_r  = 10'(row_r);
  assign cur_c  = 10'(col_r);
  assign dr     = cur_r - 10'(ra_r);
  assign dc     = cur_c - 10'(ca_r);
  assign dr_sq  = 20'(dr) * 20'(dr);
  assign dc_sq  = 20'(dc) * 20'(dc);
  assign lo_r10 = 10'(lo_r_r);
  assign hi_r10 = 10'(hi_r_r);
  assign lo_c10 = 10'(lo_c_r);
  assign hi_c10 = 10'(hi_c_r);

  // outline of the half-open box
  assign box_hit = (cur_r >= lo_r10) && (cur_r < hi_r10) &&
                   (cur_c >= lo_c10) && (cur_c < hi_c10) &&
                   ((cur_r == lo_r10) || (cur_r == hi_r10 - 10'sd1) ||
                    (cur_c == lo_c10) || (cur_c == hi_c10 - 10'sd1));

  logic          p_vld_r, p_box_r;
  logic [AW-1:0] p_addr_r;
  logic [17:0]   p_dr2_r, p_dc2_r;
  logic [18:0]   p_d2;
  logic          p_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= uc.scan && area_on;
  end

  always_ff @(posedge clk) begin
    p_addr_r <= {row_r, col_r};
    p_box_r  <= box_hit;
    p_dr2_r  <= dr_sq[17:0];
    p_dc2_r  <= dc_sq[17:0];
  end

  assign p_d2 = 19'(p_dr2_r) + 19'(p_dc2_r);

  always_comb begin
    case (act_r)
      ACT_CLEAR: p_hit = 1'b1;
      ACT_RECT:  p_hit = p_box_r;
      ACT_RING:  p_hit = (p_d2 >= 19'(inner_r)) && (p_d2 < 19'(outer_r));
      default:   p_hit = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame store: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic [AW-1:0]     cell_addr, mem_wa;
  logic [CHAR_W-1:0] mem_wd;
  logic              mem_we;

  assign cell_addr = {ra_r[RW-1:0], ca_r[CW-1:0]};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = p_addr_r;
    mem_wd = (act_r == ACT_CLEAR) ? BLANK_CHAR : fill_r;
    if (uc.wipe) begin
      mem_we = 1'b1;
      mem_wa = wipe_r;
      mem_wd = BLANK_CHAR;
    end else if (uc.cell_wr) begin
      mem_we = inside_r;
      mem_wa = cell_addr;
      mem_wd = fill_r;
    end else if (p_vld_r) begin
      mem_we = p_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we)     mem[mem_wa] <= mem_wd;
    if (uc.cell_rd) rd_data_r   <= mem[cell_addr];
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_inside_r;
  logic              load_out;

  assign load_out = uc.emit && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n)                         out_valid_r <= 1'b0;
    else if (load_out)                  out_valid_r <= 1'b1;
    else if (out_res.ready)             out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r   <= ((act_r == ACT_READ) && inside_r) ? rd_data_r : '0;
      out_inside_r <= inside_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.read_char    = out_char_r;
  assign out_res.point_inside = out_inside_r;

`ifndef NO_ASSERTIONS
  // no store write while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_IDLE) |-> !mem_we)
    else $error("frame store written in idle step");

  // scan pipeline is empty whenever a new command may enter
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_IDLE) |-> !p_vld_r)
    else $error("scan pipeline not drained at idle");

  // a read command goes to the read step
  a_read_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd.action == ACT_READ)) |=> (step_r == ST_READ))
    else $error("read command misdispatched");

  // a result appears only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r == ST_EMIT))
    else $error("result raised outside emit step");
`endif

endmodule

// ===== test/tb_raster_canvas_draw_engine.sv =====
// ----------------------------------------------------------------------------
// tb_raster_canvas_draw_engine
// Self-checking bench for the character canvas draw engine. A scoreboard
// class keeps its own copy of the frame store and the size registers. It
// predicts the read_char / point_inside pair of every command and checks
// each result transaction against it, in order.
// ----------------------------------------------------------------------------
module tb_raster_canvas_draw_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import rcde_pkg::*;

  localparam int CANVAS_ROWS = 64;
  localparam int CANVAS_COLS = 64;

  // action codes 5..7 are unused by the engine and must return an all-zero result
  localparam logic [2:0] ACT_LAST_CODE = 3'b111;

  // Longest quiet stretch of a correct run: the reset wipe or a full-canvas
  // scan, plus the receiver hold-off. Margin taken ~5x.
  localparam int WATCHDOG_LIMIT     = 25000;
  localparam int RX_HOLD_CYCLES     = 400;
  localparam int END_SETTLE_CYCLES  = 16;
  localparam int RANDOM_PER_SETTING = 19;
  localparam int MAX_REPORTS        = 10;

  typedef struct {
    logic [2:0]        action;
    logic signed [7:0] row_a;
    logic signed [7:0] col_a;
    logic signed [7:0] row_b;
    logic signed [7:0] col_b;
    logic [7:0]        radius;
    logic [7:0]        fill_char;
  } canvas_cmd_t;

  typedef struct {
    logic [7:0] read_char;
    logic       point_inside;
  } cell_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow frame store plus the queue of predicted results
  // --------------------------------------------------------------------------
  class canvas_scoreboard;
    logic [7:0]   cells [CANVAS_ROWS*CANVAS_COLS];
    int unsigned  width_reg;
    int unsigned  height_reg;
    cell_result_t pending_results [$];
    int unsigned  fail_count;
    int unsigned  results_seen;

    function new();
      foreach (cells[i]) cells[i] = BLANK_CHAR;
      width_reg    = SIZE_RESET;
      height_reg   = SIZE_RESET;
      fail_count   = 0;
      results_seen = 0;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
      if (idx == CFG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    // sizes above the store dimensions are clamped; 0 leaves no cell in use
    function int rows_used();
      return (height_reg > CANVAS_ROWS) ? CANVAS_ROWS : int'(height_reg);
    endfunction

    function int cols_used();
      return (width_reg > CANVAS_COLS) ? CANVAS_COLS : int'(width_reg);
    endfunction

    function bit in_canvas(int r, int c);
      return r >= 0 && c >= 0 && r < rows_used() && c < cols_used();
    endfunction

    // writes landing off the canvas are dropped
    function void mark(int r, int c, logic [7:0] ch);
      if (in_canvas(r, c)) cells[r*CANVAS_COLS + c] = ch;
    endfunction

    function void report_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // Predict the effect and result of one accepted command
    function void note_command(canvas_cmd_t cmd);
      cell_result_t want;
      int ra, ca, rb, cb;
      int lo_r, hi_r, lo_c, hi_c;
      int inner, outer, d2;
      ra = cmd.row_a;
      ca = cmd.col_a;
      rb = cmd.row_b;
      cb = cmd.col_b;
      want.read_char    = '0;
      want.point_inside = 1'b0;
      if (cmd.action >= ACT_SET && cmd.action <= ACT_READ)
        want.point_inside = in_canvas(ra, ca);
      case (cmd.action)
        ACT_CLEAR: begin
          // only the in-use area goes back to blanks
          for (int r = 0; r < rows_used(); r++)
            for (int c = 0; c < cols_used(); c++)
              mark(r, c, BLANK_CHAR);
        end
        ACT_SET: begin
          mark(ra, ca, cmd.fill_char);
        end
        ACT_RECT: begin
          // half-open box between sorted corners, outline only
          lo_r = (ra < rb) ? ra : rb;
          hi_r = (ra < rb) ? rb : ra;
          lo_c = (ca < cb) ? ca : cb;
          hi_c = (ca < cb) ? cb : ca;
          for (int r = lo_r; r < hi_r; r++)
            for (int c = lo_c; c < hi_c; c++)
              if (r == lo_r || r == hi_r - 1 || c == lo_c || c == hi_c - 1)
                mark(r, c, cmd.fill_char);
        end
        ACT_RING: begin
          inner = cmd.radius * cmd.radius;
          outer = (cmd.radius + 1) * (cmd.radius + 1);
          for (int r = 0; r < rows_used(); r++)
            for (int c = 0; c < cols_used(); c++) begin
              d2 = (r - ra) * (r - ra) + (c - ca) * (c - ca);
              if (d2 >= inner && d2 < outer) mark(r, c, cmd.fill_char);
            end
        end
        ACT_READ: begin
          if (want.point_inside) want.read_char = cells[ra*CANVAS_COLS + ca];
        end
        default: ;
      endcase
      pending_results.push_back(want);
    endfunction

    function void compare_result(logic [7:0] got_char, logic got_inside);
      cell_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result %0d arrived with nothing outstanding",
                                 results_seen));
        return;
      end
      want = pending_results.pop_front();
      if (got_char !== want.read_char || got_inside !== want.point_inside)
        report_failure($sformatf(
          "result %0d: read_char exp %02h got %02h, point_inside exp %0b got %0b",
          results_seen, want.read_char, got_char, want.point_inside, got_inside));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the engine
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;

  rcde_cmd_if cmd_ch ();
  rcde_res_if res_ch ();

  canvas_scoreboard board = new();

  // idle rates in percent; the main sequence sets them per phase
  int unsigned tx_idle_pct   = 33;
  int unsigned rx_idle_pct   = 48;
  // hold-off requests from the main sequence, served by the receiver
  int unsigned hold_requests = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  raster_canvas_draw_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. A hold-off request forces
  // ready low, so the result register stays full and the engine has to
  // back-pressure its command channel.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served  = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result transactions are checked at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
      board.compare_result(res_ch.read_char, res_ch.point_inside);
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run after too long without any transaction
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_raster_canvas_draw_engine failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Drive one command from the falling edge and hold it until the engine
  // takes it. Valid is left high afterwards; an idle gap of the next call or the drain lowers it.
  task automatic offer_command(input canvas_cmd_t cmd);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= cmd.action;
    cmd_ch.row_a     <= cmd.row_a;
    cmd_ch.col_a     <= cmd.col_a;
    cmd_ch.row_b     <= cmd.row_b;
    cmd_ch.col_b     <= cmd.col_b;
    cmd_ch.radius    <= cmd.radius;
    cmd_ch.fill_char <= cmd.fill_char;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    board.note_command(cmd);
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_canvas_size(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [SIZE_W-1:0]    value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    board.write_size(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic canvas_cmd_t make_cmd(logic [2:0] act, int ra, int ca, int rb,
                                           int cb, int rad, int ch);
    canvas_cmd_t cmd;
    cmd.action    = act;
    cmd.row_a     = 8'(ra);
    cmd.col_a     = 8'(ca);
    cmd.row_b     = 8'(rb);
    cmd.col_b     = 8'(cb);
    cmd.radius    = 8'(rad);
    cmd.fill_char = 8'(ch);
    return cmd;
  endfunction

  // Mostly near the canvas (up to four cells either side), sometimes anywhere
  function automatic logic signed [7:0] pick_coord(int span);
    if ($urandom_range(6) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(span + 7) - 4);
  endfunction

  function automatic canvas_cmd_t random_command();
    canvas_cmd_t cmd;
    int rows, cols, pick;
    rows = board.rows_used();
    cols = board.cols_used();
    pick = $urandom_range(99);
    if (pick < 5)       cmd.action = ACT_CLEAR;
    else if (pick < 30) cmd.action = ACT_SET;
    else if (pick < 50) cmd.action = ACT_RECT;
    else if (pick < 65) cmd.action = ACT_RING;
    else if (pick < 95) cmd.action = ACT_READ;
    else cmd.action = ACT_READ + 3'($urandom_range(1, ACT_LAST_CODE - ACT_READ));
    cmd.row_a     = pick_coord(rows);
    cmd.col_a     = pick_coord(cols);
    cmd.row_b     = pick_coord(rows);
    cmd.col_b     = pick_coord(cols);
    cmd.radius    = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range((rows > cols) ? rows : cols));
    cmd.fill_char = 8'($urandom_range(255));
    return cmd;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    // width/height per random phase: clamped, empty and one-wide canvases included
    int plan_width  [6];
    int plan_height [6];

    plan_width       = '{20, 127, 0, 1, 37, 64};
    plan_height      = '{12, 5, 9, 64, 0, 64};
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_WIDTH;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ACT_CLEAR;
    cmd_ch.row_a     = '0;
    cmd_ch.col_a     = '0;
    cmd_ch.row_b     = '0;
    cmd_ch.col_b     = '0;
    cmd_ch.radius    = '0;
    cmd_ch.fill_char = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset-size canvas (64 x 64, all blanks).
    // Ready stays low through the wipe pass; the first offer just waits.
    offer_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
    offer_command(make_cmd(ACT_SET, 0, 0, 0, 0, 0, 8'hFF));
    offer_command(make_cmd(ACT_SET, 63, 63, 0, 0, 0, 8'h00));
    // writes off the canvas: negative, far right, just below
    offer_command(make_cmd(ACT_SET, -128, 5, 0, 0, 0, 8'h55));
    offer_command(make_cmd(ACT_SET, 5, 127, 0, 0, 0, 8'hAA));
    offer_command(make_cmd(ACT_SET, 64, 0, 0, 0, 0, 8'h33));
    offer_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
    offer_command(make_cmd(ACT_READ, 63, 63, 0, 0, 0, 0));
    offer_command(make_cmd(ACT_READ, -1, -1, 0, 0, 0, 0));
    offer_command(make_cmd(ACT_READ, 127, -128, 0, 0, 0, 0));
    // full-range box: its outline lies wholly off the canvas
    offer_command(make_cmd(ACT_RECT, -128, -128, 127, 127, 0, 8'h2A));
    offer_command(make_cmd(ACT_RECT, 2, 3, 10, 20, 0, 8'h23));
    // equal row corners draw nothing; swapped corners get sorted
    offer_command(make_cmd(ACT_RECT, 5, 5, 5, 9, 0, 8'h7E));
    offer_command(make_cmd(ACT_RECT, 20, 30, 10, 25, 0, 8'h2B));
    offer_command(make_cmd(ACT_READ, 2, 10, 0, 0, 0, 0));
    offer_command(make_cmd(ACT_READ, 9, 3, 0, 0, 0, 0));
    // radius 0 marks the centre only; radius 255 from a far corner marks nothing
    offer_command(make_cmd(ACT_RING, 32, 32, 0, 0, 0, 8'h6F));
    offer_command(make_cmd(ACT_RING, -128, 127, 0, 0, 255, 8'h80));
    offer_command(make_cmd(ACT_RING, 10, 10, 0, 0, 5, 8'h40));
    offer_command(make_cmd(ACT_READ, 32, 32, 0, 0, 0, 0));
    for (int code = ACT_READ + 1; code <= ACT_LAST_CODE; code++)
      offer_command(make_cmd(3'(code), 1, 1, 4, 4, 3, 8'h11));
    offer_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    offer_command(make_cmd(ACT_READ, 2, 10, 0, 0, 0, 0));

    // Random part: six canvas settings, two per idle profile
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p / 2)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_canvas_size(CFG_WIDTH, SIZE_W'(plan_width[p]));
      write_canvas_size(CFG_HEIGHT, SIZE_W'(plan_height[p]));
      // long receiver stall while commands keep coming: fills the engine
      if (p == 3) hold_requests++;
      for (int k = 0; k < RANDOM_PER_SETTING; k++) begin
        // sender pauses mid-phase until all results are back
        if (p == 1 && k == RANDOM_PER_SETTING / 2) wait_drained();
        offer_command(random_command());
      end
    end

    wait_drained();
    repeat (END_SETTLE_CYCLES) @(posedge clk);
    if (board.pending_results.size() != 0)
      board.report_failure($sformatf("%0d results never arrived",
                                     board.pending_results.size()));

    if (board.fail_count == 0)
      $display("tb_raster_canvas_draw_engine passed");
    else
      $display("tb_raster_canvas_draw_engine failed");
    $finish;
  end

endmodule
